// ===== hw/rtl/bps_pkg.sv =====
package bps_pkg;

   // search window and offset sizing
   localparam int MAX_PATTERN_BYTES = 16;
   localparam int OFFSET_BITS       = 32;
   localparam int IDX_BITS          = $clog2(MAX_PATTERN_BYTES);

   // register widths
   localparam int PATTERN_WORD_BITS = 64;
   localparam int LEN_BITS          = 5;
   localparam int START_BITS        = 32;
   localparam int CSR_DATA_BITS     = 64;
   localparam int CSR_INDEX_BITS    = 3;

   // result field widths
   localparam int MATCH_BITS        = 32;

   // width used to compare a match start against the start offset
   localparam int CMP_BITS = (OFFSET_BITS > START_BITS) ? OFFSET_BITS : START_BITS;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LEN  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_OFFSET = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BACKWARD     = 3'd4;

   typedef logic [7:0] data_byte_type;
   typedef data_byte_type [MAX_PATTERN_BYTES-1:0] window_type;

endpackage

// ===== hw/rtl/bps_match.sv =====
module bps_match (
   input  bps_pkg::window_type                window,
   input  bps_pkg::window_type                pattern,
   input  logic [bps_pkg::LEN_BITS-1:0]       pattern_length,
   output logic                               match
);
   import bps_pkg::*;

   logic [MAX_PATTERN_BYTES-1:0] byte_eq;
   logic                         len_ok;

   // pattern byte j lines up with the byte received length-1-j steps ago
   always_comb begin
      logic [LEN_BITS-1:0] idx;
      idx = '0;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         idx = LEN_BITS'(pattern_length - LEN_BITS'(1) - LEN_BITS'(j));
         if (LEN_BITS'(j) < pattern_length) begin
            byte_eq[j] = (window[idx[IDX_BITS-1:0]] == pattern[j]);
         end else begin
            byte_eq[j] = 1'b1;
         end
      end
   end

   // empty or overlong pattern never matches
   assign len_ok = (pattern_length != '0) &&
                   (pattern_length <= LEN_BITS'(MAX_PATTERN_BYTES));

   assign match = len_ok && (&byte_eq);

endmodule

// ===== hw/rtl/byte_pattern_search.sv =====
// Streaming substring search over one buffer at a time.
// Request channel (req_): one buffer byte per request in tdata, tlast on the
// final byte of the buffer. Result channel (rsp_): one result per buffer,
// sent after its last byte; tuser carries found, tdata the match start offset
// (zero when nothing was found).
// Configuration (csr_): pattern bytes, pattern length, start offset and
// search direction; write only while no buffer is in flight.
// Throughput is one byte per cycle while no last byte waits for the result register:
// each byte is captured in an input register, and from there the 16-byte window is
// compared with the pattern and the running hit is updated in a single pass.
// A result is registered in the result register when its last byte leaves the input register.
// When the result register is full and not taken, a last byte waits in the
// input register and request ready drops; ordinary bytes keep flowing.
// Reset (synchronous) clears the configuration, valid flags and per-buffer state, but not
// the byte and result data registers; per-buffer state is also cleared after every last byte.
module byte_pattern_search (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: tdata = data_byte[7:0]; tlast = last_byte
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,
   input  logic                                 req_tlast,
   // result: tdata = match_offset[31:0]; tuser = found
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bps_pkg::MATCH_BITS-1:0]       rsp_tdata,
   output logic                                 rsp_tuser,
   // configuration write port
   input  logic                                 csr_we,
   input  logic [bps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bps_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import bps_pkg::*;

   localparam logic [OFFSET_BITS-1:0] POS_TOP = '1;

   // configuration registers
   logic [PATTERN_WORD_BITS-1:0] pat_low_ff;
   logic [PATTERN_WORD_BITS-1:0] pat_high_ff;
   logic [LEN_BITS-1:0]          pat_len_ff;
   logic [START_BITS-1:0]        start_ff;
   logic                         backward_ff;

   // input register
   logic                         in_valid_ff;
   data_byte_type                in_byte_ff;
   logic                         in_last_ff;

   // per-buffer state
   window_type                   window_ff;
   window_type                   window_in;
   logic [OFFSET_BITS-1:0]       pos_ff;
   logic [OFFSET_BITS-1:0]       pos_in;
   logic                         hit_ff;
   logic                         hit_in;
   logic [OFFSET_BITS-1:0]       hit_off_ff;
   logic [OFFSET_BITS-1:0]       hit_off_in;

   // result register
   logic                         rsp_valid_ff;
   logic                         found_ff;
   logic [MATCH_BITS-1:0]        offset_ff;

   logic                         out_free;
   logic                         proc;
   logic                         match;
   logic                         pos_ok;
   logic [LEN_BITS-1:0]          len_m1;
   logic [OFFSET_BITS-1:0]       start_pos;
   logic [CMP_BITS-1:0]          start_cmp;
   logic [CMP_BITS-1:0]          bound_cmp;
   logic [2*PATTERN_WORD_BITS-1:0] pattern_bits;
   window_type                   pattern;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
         start_ff    <= '0;
         backward_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata[PATTERN_WORD_BITS-1:0];
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata[PATTERN_WORD_BITS-1:0];
            CSR_PATTERN_LEN:  pat_len_ff  <= csr_wdata[LEN_BITS-1:0];
            CSR_START_OFFSET: start_ff    <= csr_wdata[START_BITS-1:0];
            CSR_BACKWARD:     backward_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // handshake: a last byte needs a free result register
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign proc       = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || proc;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (proc) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // window shifted by the new byte
   assign window_in = {window_ff[MAX_PATTERN_BYTES-2:0], in_byte_ff};

   assign pattern_bits = {pat_high_ff, pat_low_ff};
   assign pattern      = pattern_bits[MAX_PATTERN_BYTES*8-1:0];

   bps_match u_match (
      .window         (window_in),
      .pattern        (pattern),
      .pattern_length (pat_len_ff),
      .match          (match)
   );

   // candidate match start and its bound check
   assign len_m1    = LEN_BITS'(pat_len_ff - LEN_BITS'(1));
   assign pos_ok    = (pos_ff >= OFFSET_BITS'(len_m1));
   assign start_pos = OFFSET_BITS'(pos_ff - OFFSET_BITS'(len_m1));
   assign start_cmp = CMP_BITS'(start_pos);
   assign bound_cmp = CMP_BITS'(start_ff);

   // running hit and saturating position
   always_comb begin
      hit_in     = hit_ff;
      hit_off_in = hit_off_ff;
      if (match && pos_ok) begin
         if (backward_ff) begin
            if (start_cmp <= bound_cmp) begin
               hit_in     = 1'b1;
               hit_off_in = start_pos;
            end
         end else if (!hit_ff && (start_cmp >= bound_cmp)) begin
            hit_in     = 1'b1;
            hit_off_in = start_pos;
         end
      end
      pos_in = (pos_ff == POS_TOP) ? pos_ff : OFFSET_BITS'(pos_ff + OFFSET_BITS'(1));
   end

   // per-buffer state, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         pos_ff     <= '0;
         hit_ff     <= 1'b0;
         hit_off_ff <= '0;
      end else if (proc) begin
         if (in_last_ff) begin
            window_ff  <= '0;
            pos_ff     <= '0;
            hit_ff     <= 1'b0;
            hit_off_ff <= '0;
         end else begin
            window_ff  <= window_in;
            pos_ff     <= pos_in;
            hit_ff     <= hit_in;
            hit_off_ff <= hit_off_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && in_last_ff) begin
         found_ff  <= hit_in;
         offset_ff <= hit_in ? MATCH_BITS'(hit_off_in) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = offset_ff;

   // a waiting byte is held until it is processed
   a_input_held : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("input register overwritten before processing");

   // state is back to reset after a last byte
   a_state_cleared : assert property (@(posedge clock) disable iff (reset)
      proc && in_last_ff |=> pos_ff == '0 && !hit_ff)
      else $error("buffer state not cleared after last byte");

   // a kept match start never lies ahead of the current position
   a_hit_behind_pos : assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> hit_off_ff <= pos_ff)
      else $error("hit offset beyond byte position");

   // not-found results carry a zero offset
   a_zero_offset : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> offset_ff == '0)
      else $error("offset not zero on a not-found result");

endmodule

// ===== verif/tb_byte_pattern_search.sv =====
`timescale 1ns / 100ps

module tb_byte_pattern_search;
   import bps_pkg::*;

   localparam int ITEM_TARGET  = 1350;
   localparam int DRAIN_CYCLES = 6;
   localparam int TIMEOUT_NS   = 5_000_000;

   // register indexes the block decodes to nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_C = 3'd7;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [7:0]                  req_tdata;
   logic                        req_tlast;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [MATCH_BITS-1:0]       rsp_tdata;
   logic                        rsp_tuser;
   logic                        csr_we;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;

   byte_pattern_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   typedef struct packed {
      logic                  found;
      logic [MATCH_BITS-1:0] offset;
   } search_result_type;

   typedef enum logic {ROW_CSR, ROW_BYTE} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  value;
      logic [7:0]                data;
      logic                      lst;
      logic                      typed;
      logic                      found;
      logic [MATCH_BITS-1:0]     offset;
   } stim_row_type;

   // directed opening: zero length, byte extremes, both directions, bounds
   // past the end, pattern longer than buffer, spare indexes, overlong length
   localparam int DIRECTED_ROWS = 42;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_BYTE, '0, '0, 8'h00, 1'b1, 1'b1, 1'b0, 32'd0},
      '{ROW_CSR, CSR_PATTERN_LEN, 64'd1, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_PATTERN_LOW, 64'hFF, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 1'b1, 32'd1},
      '{ROW_CSR, CSR_PATTERN_LOW, 64'h4241, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_PATTERN_LEN, 64'd2, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h41, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h42, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h41, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h42, 1'b1, 1'b1, 1'b1, 32'd0},
      '{ROW_CSR, CSR_START_OFFSET, 64'd1, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h41, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h42, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h41, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h42, 1'b1, 1'b1, 1'b1, 32'd2},
      '{ROW_CSR, CSR_BACKWARD, 64'd1, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h41, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h42, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h41, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h42, 1'b1, 1'b1, 1'b1, 32'd0},
      '{ROW_CSR, CSR_START_OFFSET, '1, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h41, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h42, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h41, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h42, 1'b1, 1'b1, 1'b1, 32'd2},
      '{ROW_CSR, CSR_BACKWARD, 64'hFFFF_FFFF_FFFF_FFFE, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h41, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h42, 1'b1, 1'b1, 1'b0, 32'd0},
      '{ROW_CSR, CSR_PATTERN_LOW, '1, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_PATTERN_HIGH, '1, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_PATTERN_LEN, 64'd16, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_START_OFFSET, 64'd0, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 1'b0, 32'd0},
      '{ROW_CSR, CSR_SPARE_A, 64'd0, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_SPARE_B, 64'd0, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_SPARE_C, '1, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_PATTERN_LEN, 64'd1, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 1'b1, 32'd0},
      '{ROW_CSR, CSR_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFF1, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_BYTE, '0, '0, 8'h80, 1'b1, 1'b1, 1'b0, 32'd0}
   };

   // mirrored configuration
   logic [63:0]             cfg_pat_lo;
   logic [63:0]             cfg_pat_hi;
   logic [LEN_BITS-1:0]     cfg_len;
   logic [START_BITS-1:0]   cfg_start;
   logic                    cfg_backward;

   // per-buffer search state
   logic [7:0]              recent_bytes [MAX_PATTERN_BYTES];
   logic [OFFSET_BITS-1:0]  next_pos;
   logic                    hit_seen;
   logic [OFFSET_BITS-1:0]  hit_offset;

   search_result_type       pending_results [$];
   int                      mismatch_count = 0;
   bit                      req_steady = 1'b0;

   task automatic report_mismatch(input string what, input logic [MATCH_BITS-1:0] got,
                                  input logic [MATCH_BITS-1:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic clear_search();
      foreach (recent_bytes[k]) recent_bytes[k] = 8'h00;
      next_pos   = '0;
      hit_seen   = 1'b0;
      hit_offset = '0;
   endtask

   function automatic logic [7:0] pattern_at(input int j);
      if (j < 8) return cfg_pat_lo[8*j +: 8];
      return cfg_pat_hi[8*(j-8) +: 8];
   endfunction

   // shift in one byte, test the match ending here, close the buffer on last
   task automatic advance_search(input logic [7:0] data, input logic lst,
                                 output bit done, output search_result_type res);
      int unsigned            len;
      logic [OFFSET_BITS-1:0] pos;
      logic [OFFSET_BITS-1:0] match_start;
      bit                     hit;
      len = 32'(cfg_len);
      pos = next_pos;
      for (int k = MAX_PATTERN_BYTES - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = data;
      hit = (len >= 1) && (len <= MAX_PATTERN_BYTES) && (pos >= len - 1);
      if (hit) begin
         for (int j = 0; j < len; j++) begin
            if (recent_bytes[len-1-j] != pattern_at(j)) hit = 1'b0;
         end
      end
      if (hit) begin
         match_start = pos - (len - 1);
         if (cfg_backward) begin
            if (match_start <= cfg_start) begin
               hit_seen   = 1'b1;
               hit_offset = match_start;
            end
         end else if (!hit_seen && match_start >= cfg_start) begin
            hit_seen   = 1'b1;
            hit_offset = match_start;
         end
      end
      if (next_pos != '1) next_pos++;
      done       = lst;
      res.found  = hit_seen;
      res.offset = hit_seen ? hit_offset[MATCH_BITS-1:0] : '0;
      if (lst) clear_search();
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int request_gap();
      int r;
      r = $urandom_range(0, 99);
      if (req_steady || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // one request, predicted once accepted; starts and ends on a falling edge
   task automatic send_byte(input logic [7:0] data, input logic lst,
                            input logic typed, input search_result_type typed_res);
      int                gap;
      bit                done;
      search_result_type res;
      gap = request_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= lst;
      do @(posedge clock); while (req_tready !== 1'b1);
      advance_search(data, lst, done, res);
      if (done) pending_results.insert(pending_results.size(), typed ? typed_res : res);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (index)
         CSR_PATTERN_LOW:  cfg_pat_lo   = value;
         CSR_PATTERN_HIGH: cfg_pat_hi   = value;
         CSR_PATTERN_LEN:  cfg_len      = value[LEN_BITS-1:0];
         CSR_START_OFFSET: cfg_start    = value[START_BITS-1:0];
         CSR_BACKWARD:     cfg_backward = value[0];
         default: ;
      endcase
   endtask

   // block idle: every result back and the pipeline drained
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side stalls: long open stretches, short stalls, a few long ones
   initial begin
      int run;
      int stall;
      int r;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
         r = $urandom_range(0, 99);
         if (r < 80) stall = $urandom_range(1, 3);
         else if (r < 95) stall = $urandom_range(4, 12);
         else stall = $urandom_range(20, 50);
         rsp_tready <= 1'b1;
         repeat (run) @(negedge clock);
         rsp_tready <= 1'b0;
         repeat (stall) @(negedge clock);
      end
   end

   // result checking against the oldest pending expectation
   always @(posedge clock) begin
      search_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_tdata, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.found) begin
               report_mismatch("found", MATCH_BITS'(rsp_tuser), MATCH_BITS'(want.found));
            end
            if (rsp_tdata !== want.offset) report_mismatch("match offset", rsp_tdata, want.offset);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

   initial begin
      stim_row_type          row;
      logic [7:0]            pat [MAX_PATTERN_BYTES];
      logic [CSR_DATA_BITS-1:0] csr_value;
      logic [7:0]            sym_a;
      logic [7:0]            sym_b;
      logic [7:0]            stream_bytes [$];
      bit                    narrow;
      int                    plen;
      int                    stream_len;
      int                    n_buf;
      int                    r;
      int                    random_bytes;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      req_tlast    = 1'b0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      cfg_pat_lo   = '0;
      cfg_pat_hi   = '0;
      cfg_len      = '0;
      cfg_start    = '0;
      cfg_backward = 1'b0;
      clear_search();
      random_bytes = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_csr(row.index, row.value);
         end else begin
            send_byte(row.data, row.lst, row.typed, {row.found, row.offset});
         end
      end

      // random phases: new settings, then a few buffers under them
      while (random_bytes < ITEM_TARGET) begin
         wait_idle();
         r = $urandom_range(0, 99);
         if (r < 6) plen = 0;
         else if (r < 12) plen = $urandom_range(MAX_PATTERN_BYTES + 1, 31);
         else if (r < 55) plen = $urandom_range(1, 4);
         else if (r < 82) plen = $urandom_range(5, 10);
         else plen = $urandom_range(11, MAX_PATTERN_BYTES);

         // a two-symbol alphabet makes overlapping and repeated matches common
         narrow = 1'($urandom_range(0, 1));
         sym_a  = 8'($urandom_range(0, 255));
         sym_b  = 8'($urandom_range(0, 255));
         foreach (pat[j]) begin
            if (narrow) pat[j] = $urandom_range(0, 1) ? sym_a : sym_b;
            else pat[j] = 8'($urandom_range(0, 255));
         end

         for (int j = 0; j < 8; j++) csr_value[8*j +: 8] = pat[j];
         write_csr(CSR_PATTERN_LOW, csr_value);
         for (int j = 0; j < 8; j++) csr_value[8*j +: 8] = pat[8+j];
         write_csr(CSR_PATTERN_HIGH, csr_value);
         csr_value = {$urandom(), $urandom()};
         csr_value[LEN_BITS-1:0] = LEN_BITS'(plen);
         write_csr(CSR_PATTERN_LEN, csr_value);
         csr_value = {$urandom(), $urandom()};
         r = $urandom_range(0, 99);
         if (r < 25) csr_value[START_BITS-1:0] = '0;
         else if (r < 35) csr_value[START_BITS-1:0] = '1;
         else if (r >= 45) csr_value[START_BITS-1:0] = $urandom_range(0, 60);
         write_csr(CSR_START_OFFSET, csr_value);
         write_csr(CSR_BACKWARD, {$urandom(), $urandom()});
         if ($urandom_range(0, 7) == 0) begin
            write_csr(CSR_INDEX_BITS'($urandom_range(CSR_SPARE_A, CSR_SPARE_C)),
                      {$urandom(), $urandom()});
         end

         n_buf = $urandom_range(1, 6);
         repeat (n_buf) begin
            r = $urandom_range(0, 99);
            if (r < 85) stream_len = $urandom_range(1, 24);
            else if (r < 97) stream_len = $urandom_range(25, 80);
            else stream_len = $urandom_range(81, 300);

            // random bytes with copies of the pattern planted here and there
            stream_bytes.delete();
            while (stream_bytes.size() < stream_len) begin
               if (plen >= 1 && plen <= MAX_PATTERN_BYTES && $urandom_range(0, 5) == 0
                   && stream_bytes.size() + plen <= stream_len) begin
                  for (int j = 0; j < plen; j++) begin
                     stream_bytes.insert(stream_bytes.size(), pat[j]);
                  end
               end else if (narrow) begin
                  stream_bytes.insert(stream_bytes.size(),
                                      $urandom_range(0, 1) ? sym_a : sym_b);
               end else begin
                  stream_bytes.insert(stream_bytes.size(), 8'($urandom_range(0, 255)));
               end
            end

            req_steady = ($urandom_range(0, 4) == 0);
            foreach (stream_bytes[i]) begin
               send_byte(stream_bytes[i], i == stream_len - 1, 1'b0, '0);
               random_bytes++;
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
